// ===== rtl/core/rlef_pkg.sv =====
// Shared types, codes and helpers for the leader-election node.
package rlef_pkg;

    // Action codes of an input word
    localparam logic [1:0] ACT_RECV  = 2'd0;
    localparam logic [1:0] ACT_TMOUT = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Packet kinds, received and sent
    localparam logic [1:0] MSG_VREQ = 2'd0;
    localparam logic [1:0] MSG_VRSP = 2'd1;
    localparam logic [1:0] MSG_HB   = 2'd2;

    // Election timer commands
    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_RESTART = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;

    // Role codes as reported on the result word
    localparam logic [1:0] RC_FOLLOWER  = 2'd0;
    localparam logic [1:0] RC_CANDIDATE = 2'd1;
    localparam logic [1:0] RC_LEADER    = 2'd2;

    // Most packets one broadcast may emit
    localparam logic [4:0] MAX_PKTS = 5'd30;

    // Node role state, one-hot
    typedef enum logic [2:0] {
        ROLE_FOLLOWER  = 3'b001,
        ROLE_CANDIDATE = 3'b010,
        ROLE_LEADER    = 3'b100
    } t_role;

    // What the back end must emit for one input
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_BCAST  = 2'd2
    } t_kind;

    // Classified work handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  send_type;
        logic [4:0]  dest;
        logic [4:0]  self_id;
        logic [4:0]  total;
        logic [1:0]  timer_cmd;
        logic [1:0]  role_code;
        logic [31:0] term;
    } t_job;

    function automatic logic [1:0] role_code(input t_role r);
        logic [1:0] c;
        c = RC_FOLLOWER;
        unique case (r)
            ROLE_FOLLOWER:  c = RC_FOLLOWER;
            ROLE_CANDIDATE: c = RC_CANDIDATE;
            ROLE_LEADER:    c = RC_LEADER;
            default:        c = RC_FOLLOWER;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/rlef_front.sv =====
// Front end: accepts events, updates the election state and classifies the work.
module rlef_front import rlef_pkg::*; #(
    parameter int NODE_COUNT = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_valid,
    input  logic        i_q_ready,
    input  logic [1:0]  i_action,
    input  logic [1:0]  i_msg_type,
    input  logic [31:0] i_pkt_term,
    input  logic [4:0]  i_sender_id,
    output logic        o_push,
    output t_job        o_job
);

    localparam logic [4:0] NODES    = 5'(NODE_COUNT);
    localparam logic [4:0] MAJ_HALF = 5'(NODE_COUNT / 2);

    t_role       r_role,  n_role;
    logic [31:0] r_term,  n_term;
    logic [4:0]  r_voted, n_voted;
    logic [4:0]  r_vcnt,  n_vcnt;
    logic [4:0]  r_self;

    logic        self_in;
    logic [4:0]  peers;
    logic [4:0]  total;
    logic        accept;

    assign accept = i_valid && i_q_ready;
    assign o_push = accept;

    // Count the peers a broadcast reaches, capped
    assign self_in = (r_self != 5'd0) && (r_self <= NODES);
    assign peers   = NODES - {4'd0, self_in};
    assign total   = (peers > MAX_PKTS) ? MAX_PKTS : peers;

    // Apply one event to the node state
    always_comb begin
        n_role  = r_role;
        n_term  = r_term;
        n_voted = r_voted;
        n_vcnt  = r_vcnt;
        o_job           = '0;
        o_job.kind      = KIND_NONE;
        o_job.self_id   = r_self;
        o_job.total     = total;
        o_job.timer_cmd = TMR_NONE;
        unique case (i_action)
            ACT_RECV: begin
                if (i_pkt_term > n_term) begin
                    n_term  = i_pkt_term;
                    n_role  = ROLE_FOLLOWER;
                    n_voted = 5'd0;
                    o_job.timer_cmd = TMR_RESTART;
                end
                unique case (i_msg_type)
                    MSG_VREQ: begin
                        if (n_role == ROLE_FOLLOWER && i_pkt_term >= n_term &&
                            i_sender_id != 5'd0 && i_sender_id <= NODES &&
                            (n_voted == 5'd0 || n_voted == i_sender_id)) begin
                            n_voted         = i_sender_id;
                            o_job.timer_cmd = TMR_RESTART;
                            o_job.kind      = KIND_SINGLE;
                            o_job.send_type = MSG_VRSP;
                            o_job.dest      = i_sender_id;
                        end
                    end
                    MSG_VRSP: begin
                        if (n_role == ROLE_CANDIDATE && i_pkt_term == n_term) begin
                            if (n_vcnt < NODES) begin
                                n_vcnt = n_vcnt + 5'd1;
                            end
                            if (n_vcnt > MAJ_HALF) begin
                                n_role          = ROLE_LEADER;
                                o_job.kind      = KIND_BCAST;
                                o_job.send_type = MSG_HB;
                                o_job.timer_cmd = TMR_STOP;
                            end
                        end
                    end
                    MSG_HB: begin
                        if (i_pkt_term >= n_term) begin
                            n_role          = ROLE_FOLLOWER;
                            n_term          = i_pkt_term;
                            o_job.timer_cmd = TMR_RESTART;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_TMOUT: begin
                if (r_role != ROLE_LEADER) begin
                    n_role          = ROLE_CANDIDATE;
                    n_term          = r_term + 32'd1;
                    n_voted         = r_self;
                    n_vcnt          = 5'd1;
                    o_job.kind      = KIND_BCAST;
                    o_job.send_type = MSG_VREQ;
                    o_job.timer_cmd = TMR_RESTART;
                end
            end
            ACT_TICK: begin
                if (r_role == ROLE_LEADER) begin
                    o_job.kind      = KIND_BCAST;
                    o_job.send_type = MSG_HB;
                end
            end
            default: ;
        endcase
        o_job.role_code = role_code(n_role);
        o_job.term      = n_term;
    end

    // Commit state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role  <= ROLE_FOLLOWER;
            r_term  <= 32'd0;
            r_voted <= 5'd0;
            r_vcnt  <= 5'd0;
        end else if (accept) begin
            r_role  <= n_role;
            r_term  <= n_term;
            r_voted <= n_voted;
            r_vcnt  <= n_vcnt;
        end
    end

    // Hold the node identifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self <= 5'd1;
        end else if (i_cfg_we) begin
            r_self <= i_cfg_wdata;
        end
    end

endmodule

// ===== rtl/core/rlef_queue.sv =====
// Two-entry job queue between front and back ends.
module rlef_queue import rlef_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_wready,
    output logic o_rvalid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_wready = (r_cnt != 2'd2);
    assign o_rvalid = (r_cnt != 2'd0);
    assign o_job    = r_mem[r_rp];
    assign do_push  = i_push && o_wready;
    assign do_pop   = i_pop && o_rvalid;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== rtl/core/rlef_back.sv =====
// Back end: expands each job into result words, one per cycle while the receiver takes them.
module rlef_back import rlef_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_jvalid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_send_valid,
    output logic [1:0]  o_send_type,
    output logic [31:0] o_send_term,
    output logic [4:0]  o_dest_node,
    output logic [1:0]  o_timer_cmd,
    output logic [1:0]  o_node_role,
    output logic [31:0] o_term_now,
    output logic        o_last
);

    logic [4:0]  r_peer;
    logic [4:0]  r_cnt;
    logic        r_ovalid;
    logic        r_sv;
    logic [1:0]  r_st;
    logic [31:0] r_sterm;
    logic [4:0]  r_dest;
    logic [1:0]  r_tcmd;
    logic [1:0]  r_role;
    logic [31:0] r_term;
    logic        r_last;

    logic        load;
    logic [4:0]  emit;
    logic        bc_last;
    logic        n_sv;
    logic [1:0]  n_st;
    logic [31:0] n_sterm;
    logic [4:0]  n_dest;
    logic [1:0]  n_tcmd;
    logic        n_last;

    assign load    = i_jvalid && (!r_ovalid || i_ready);
    assign emit    = (r_peer == i_job.self_id) ? r_peer + 5'd1 : r_peer;
    assign bc_last = (r_cnt + 5'd1 == i_job.total);

    // Build the next result word
    always_comb begin
        n_sv    = 1'b0;
        n_st    = 2'd0;
        n_sterm = 32'd0;
        n_dest  = 5'd0;
        n_tcmd  = i_job.timer_cmd;
        n_last  = 1'b1;
        unique case (i_job.kind)
            KIND_SINGLE: begin
                n_sv    = 1'b1;
                n_st    = i_job.send_type;
                n_sterm = i_job.term;
                n_dest  = i_job.dest;
            end
            KIND_BCAST: begin
                n_sv    = 1'b1;
                n_st    = i_job.send_type;
                n_sterm = i_job.term;
                n_dest  = emit;
                n_last  = bc_last;
                n_tcmd  = bc_last ? i_job.timer_cmd : TMR_NONE;
            end
            default: ;
        endcase
    end

    assign o_pop = load && n_last;

    // Walk the peer list of a broadcast
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer <= 5'd1;
            r_cnt  <= 5'd0;
        end else if (load && i_job.kind == KIND_BCAST) begin
            if (bc_last) begin
                r_peer <= 5'd1;
                r_cnt  <= 5'd0;
            end else begin
                r_peer <= emit + 5'd1;
                r_cnt  <= r_cnt + 5'd1;
            end
        end
    end

    // Hold the output word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sv    <= n_sv;
            r_st    <= n_st;
            r_sterm <= n_sterm;
            r_dest  <= n_dest;
            r_tcmd  <= n_tcmd;
            r_role  <= i_job.role_code;
            r_term  <= i_job.term;
            r_last  <= n_last;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_send_valid = r_sv;
    assign o_send_type  = r_st;
    assign o_send_term  = r_sterm;
    assign o_dest_node  = r_dest;
    assign o_timer_cmd  = r_tcmd;
    assign o_node_role  = r_role;
    assign o_term_now   = r_term;
    assign o_last       = r_last;

endmodule

// ===== rtl/core/raft_leader_election_fsm_unit.sv =====
// Top level of the leader-election node: front end, job queue and back end.
// Usage:
//   Input channel (i_valid/o_ready) carries one event word: a received packet,
//   an election timer expiry or a heartbeat tick. The front end updates role,
//   term, vote and vote count in the cycle the word is accepted.
//   Output channel (o_valid/i_ready) carries result words; o_last marks the
//   final word of an event. A vote response or an empty result is one word,
//   a broadcast is one word per peer addressed (NODE_COUNT-1, or NODE_COUNT
//   capped at 30 when the node identifier is outside 1..NODE_COUNT).
//   An accepted word is written into the job queue, then loaded into the back
//   end's output register, which drives o_valid.
//   The back end emits one result word per cycle while the receiver takes them.
//   A two-entry job queue lets the front accept new words while a broadcast
//   is still being expanded; o_ready drops only when the queue is full.
//   A stalled receiver holds the current output word; the queue backs up.
//   Reset (i_rst_n low, synchronous) makes the node a follower in term 0
//   with no vote, empties the queue and sets the node identifier to 1.
//   The user must use i_cfg_we/i_cfg_wdata to write the node identifier only
//   while the block is idle; the block itself does not enforce this.
module raft_leader_election_fsm_unit import rlef_pkg::*; #(
    parameter int NODE_COUNT = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [1:0]  i_msg_type,
    input  logic [31:0] i_pkt_term,
    input  logic [4:0]  i_sender_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_send_valid,
    output logic [1:0]  o_send_type,
    output logic [31:0] o_send_term,
    output logic [4:0]  o_dest_node,
    output logic [1:0]  o_timer_cmd,
    output logic [1:0]  o_node_role,
    output logic [31:0] o_term_now,
    output logic        o_last
);

    logic push;
    t_job push_job;
    logic q_wready;
    logic q_rvalid;
    t_job q_job;
    logic pop;

    assign o_ready = q_wready;

    rlef_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_q_ready   (q_wready),
        .i_action    (i_action),
        .i_msg_type  (i_msg_type),
        .i_pkt_term  (i_pkt_term),
        .i_sender_id (i_sender_id),
        .o_push      (push),
        .o_job       (push_job)
    );

    rlef_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .o_wready (q_wready),
        .o_rvalid (q_rvalid),
        .o_job    (q_job),
        .i_pop    (pop)
    );

    rlef_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_jvalid     (q_rvalid),
        .i_job        (q_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_send_valid (o_send_valid),
        .o_send_type  (o_send_type),
        .o_send_term  (o_send_term),
        .o_dest_node  (o_dest_node),
        .o_timer_cmd  (o_timer_cmd),
        .o_node_role  (o_node_role),
        .o_term_now   (o_term_now),
        .o_last       (o_last)
    );

`ifndef ASSERT_OFF
    // An empty result always closes its event
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_send_valid |-> o_last)
        else $error("empty result not marked last");

    // Timer command rides only on the final word
    a_tcmd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_timer_cmd == TMR_NONE)
        else $error("timer command on a non-final word");

    // A vote response is a single-word result
    a_vrsp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_valid && o_send_type == MSG_VRSP |-> o_last)
        else $error("vote response not last");

    // Sent packets never address node zero
    a_dest_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_send_valid |-> o_dest_node != 5'd0)
        else $error("packet sent to node zero");
`endif

endmodule
